// ===== rtl/lcg_random_in_range_macros.svh =====
`ifndef LCG_RANDOM_IN_RANGE_MACROS_SVH
`define LCG_RANDOM_IN_RANGE_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define LCGR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lcgr assertion failed");

// next-cycle implication
`define LCGR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lcgr assertion failed");

`endif

// ===== rtl/lcgr_pkg.sv =====
package lcgr_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned ADDR_W = 2;

	localparam logic [DATA_W-1:0] LCG_MUL    = 32'd1859;
	localparam logic [DATA_W-1:0] LCG_ADD    = 32'd3719;
	localparam logic [DATA_W-1:0] SPAN_LIMIT = 32'h7FFF_FFFF;

	// register map
	localparam logic [ADDR_W-1:0] ADDR_START_SEED = 2'd0;

	// how the result word is formed
	localparam logic [1:0] KIND_LOW = 2'd0;
	localparam logic [1:0] KIND_ERR = 2'd1;
	localparam logic [1:0] KIND_SUM = 2'd2;

	// divider operand select
	localparam logic DIV_SEL_SCALE = 1'b0;
	localparam logic DIV_SEL_DRAW  = 1'b1;

	typedef struct packed {
		logic signed [DATA_W-1:0] range_low;
		logic signed [DATA_W-1:0] range_high;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     range_error;
	} rsp_t;

	typedef struct packed {
		logic       load;
		logic       reseed;
		logic       advance;
		logic       div_start;
		logic       div_sel;
		logic       out_load;
		logic [1:0] kind;
	} ctrl_cmd_t;

	typedef struct packed {
		logic empty;
		logic seed_zero;
		logic span_big;
		logic div_busy;
		logic out_free;
	} dp_status_t;

endpackage

// ===== rtl/lcg_random_in_range.sv =====
// a normal draw checks the range, reloads the seed if it is zero, advances it and runs
//   two 32-step radix-2 divisions in turn; an empty range or oversized span skips them
// a new request is taken only in idle, once the last word has entered the result register
// a new word is computed while the last one waits, and loads only once that one is taken
// reset: arst_n clears the seed (unseeded), the start seed, the state machine and out_valid
module lcg_random_in_range import lcgr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              in_valid,
	output logic              in_ready,
	input  req_t              in_data,
	// result channel
	output logic              out_valid,
	input  logic              out_ready,
	output rsp_t              out_data,
	// register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [DATA_W-1:0] start_seed_q;
	ctrl_cmd_t         cmd;
	dp_status_t        status;

	// register port: pready tied high, single register at offset zero
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_seed_q <= '0;
		end else if (psel && penable && pwrite && (paddr == ADDR_START_SEED)) begin
			start_seed_q <= pwdata;
		end
	end

	// unmapped offsets read back as zero
	assign prdata = (paddr == ADDR_START_SEED) ? start_seed_q : '0;

	// sequencer: check range, reseed if needed, advance, scale, divide, emit
	lcgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// seed, bounds, shared divider and result register
	lcgr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_data    (in_data),
		.start_seed (start_seed_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// ===== rtl/lcgr_div.sv =====
`include "lcg_random_in_range_macros.svh"

module lcgr_div import lcgr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              busy,
	output logic [DATA_W-1:0] quotient
);

	localparam int unsigned CNT_W = $clog2(DATA_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dsr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   trial;

	// restoring radix-2 step: one quotient bit per cycle
	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign trial   = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DATA_W]) begin
				rem_q <= trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

	`LCGR_ASSERT_NEXT(a_start_busy, clk, arst_n, start, busy_q && cnt_q == '0)
	`LCGR_ASSERT_NEXT(a_last_step, clk, arst_n, busy_q && !start && cnt_q == CNT_LAST, !busy_q)

endmodule

// ===== rtl/lcgr_dp.sv =====
module lcgr_dp import lcgr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_cmd_t         cmd,
	output dp_status_t        status,
	input  req_t              in_data,
	input  logic [DATA_W-1:0] start_seed,
	output logic              out_valid,
	input  logic              out_ready,
	output rsp_t              out_data
);

	logic signed [DATA_W-1:0] lo_q;
	logic signed [DATA_W-1:0] hi_q;
	logic [DATA_W-1:0]        seed_q;
	logic                     out_valid_q;
	rsp_t                     out_q;
	logic [DATA_W:0]          span;
	logic [DATA_W-1:0]        mag;
	logic [DATA_W-1:0]        div_dividend;
	logic [DATA_W-1:0]        div_divisor;
	logic [DATA_W-1:0]        div_quo;
	logic                     div_busy;

	// span = hi - lo + 1 in one extra bit
	assign span = {hi_q[DATA_W-1], hi_q} - {lo_q[DATA_W-1], lo_q} + 1'b1;
	// magnitude of the seed read as signed; the most negative seed gives 2^31
	assign mag  = seed_q[DATA_W-1] ? (~seed_q + 1'b1) : seed_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q <= in_data.range_low;
			hi_q <= in_data.range_high;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cmd.reseed) begin
			seed_q <= start_seed * LCG_MUL + LCG_ADD;
		end else if (cmd.advance) begin
			seed_q <= seed_q * LCG_MUL + LCG_ADD;
		end
	end

	always_comb begin
		if (cmd.div_sel == DIV_SEL_DRAW) begin
			div_dividend = mag;
			div_divisor  = div_quo;
		end else begin
			div_dividend = SPAN_LIMIT;
			div_divisor  = span[DATA_W-1:0];
		end
	end

	lcgr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.kind)
				KIND_SUM: begin
					out_q.value       <= lo_q + $signed(div_quo);
					out_q.range_error <= 1'b0;
				end
				KIND_ERR: begin
					out_q.value       <= lo_q;
					out_q.range_error <= 1'b1;
				end
				default: begin
					out_q.value       <= lo_q;
					out_q.range_error <= 1'b0;
				end
			endcase
		end
	end

	assign status.empty     = (hi_q <= lo_q);
	assign status.seed_zero = (seed_q == '0);
	assign status.span_big  = (span > {1'b0, SPAN_LIMIT});
	assign status.div_busy  = div_busy;
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/lcgr_ctrl.sv =====
`include "lcg_random_in_range_macros.svh"

module lcgr_ctrl import lcgr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_CHECK   = 3'd1;
	localparam logic [2:0] ST_RESEED  = 3'd2;
	localparam logic [2:0] ST_ADVANCE = 3'd3;
	localparam logic [2:0] ST_DRAW    = 3'd4;
	localparam logic [2:0] ST_DIVA    = 3'd5;
	localparam logic [2:0] ST_DIVB    = 3'd6;
	localparam logic [2:0] ST_FINISH  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] kind_q;
	logic [1:0] kind_d;

	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.empty) begin
					kind_d  = KIND_LOW;
					state_d = ST_FINISH;
				end else if (status.seed_zero) begin
					state_d = ST_RESEED;
				end else begin
					state_d = ST_ADVANCE;
				end
			end
			ST_RESEED: begin
				cmd.reseed = 1'b1;
				state_d    = ST_ADVANCE;
			end
			ST_ADVANCE: begin
				cmd.advance = 1'b1;
				state_d     = ST_DRAW;
			end
			ST_DRAW: begin
				if (status.span_big) begin
					kind_d  = KIND_ERR;
					state_d = ST_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_SEL_SCALE;
					state_d       = ST_DIVA;
				end
			end
			ST_DIVA: begin
				if (!status.div_busy) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_SEL_DRAW;
					state_d       = ST_DIVB;
				end
			end
			ST_DIVB: begin
				cmd.div_sel = DIV_SEL_DRAW;
				if (!status.div_busy) begin
					kind_d  = KIND_SUM;
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.kind = kind_q;
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= KIND_LOW;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	`LCGR_ASSERT_NOW(a_start_idle_div, clk, arst_n, cmd.div_start, !status.div_busy)
	`LCGR_ASSERT_NOW(a_load_free_slot, clk, arst_n, cmd.out_load, status.out_free)

endmodule
